[sv/quantized_mlp_evaluator_unit_macros.svh]
// assertion macros shared by the evaluator modules
// each one expects clk and rst_n in the scope of its use
`ifndef QUANTIZED_MLP_EVALUATOR_UNIT_MACROS_SVH
`define QUANTIZED_MLP_EVALUATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QMLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qmlp assertion failed");

// next-cycle implication
`define QMLP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qmlp assertion failed");

`else

`define QMLP_ASSERT_IMP(label, ante, cons)

`define QMLP_ASSERT_NXT(label, ante, cons)

`endif

`endif

[sv/qmlp_pkg.sv]
package qmlp_pkg;

    // activation value, 0..127
    typedef logic [6:0] act_t;

    // sideband that travels with each word through the pipeline
    typedef struct packed {
        logic        eval;
        logic        side;
        logic        ours;
        logic [7:0]  addr;
        logic [15:0] value;
    } ctl_t;

    localparam act_t        ACT_MAX            = 7'd127;
    localparam int          HIDDEN_SHIFT       = 6;
    localparam logic [15:0] PERSPECTIVE_OFFSET = 16'd4096;

    // clip an int16 accumulator to 0..127
    function automatic act_t clip_input(input logic [15:0] v);
        if (v[15])
        begin
            return '0;
        end
        else if (v > 16'(ACT_MAX))
        begin
            return ACT_MAX;
        end
        else
        begin
            return v[6:0];
        end
    endfunction

    // arithmetic shift, relu, saturate to 0..127
    function automatic act_t activate(input logic [15:0] v);
        logic [15:0] sh;
        sh = 16'($signed(v) >>> HIDDEN_SHIFT);
        if (v[15])
        begin
            return '0;
        end
        else if (sh > 16'(ACT_MAX))
        begin
            return ACT_MAX;
        end
        else
        begin
            return sh[6:0];
        end
    endfunction

    // unsigned activation times int8 weight, kept mod 2^16
    function automatic logic [15:0] mul_act_weight(input act_t x, input logic [7:0] w);
        return 16'($signed({9'b0, x}) * $signed({{8{w[7]}}, w}));
    endfunction

endpackage

[sv/qmlp_req_if.sv]
interface qmlp_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [7:0]         param_address;
    logic signed [15:0] param_value;
    logic               side_to_move;
    logic               our_perspective;
    logic [63:0]        acc_low;
    logic [63:0]        acc_high;

    modport source (
        output valid, mode, param_address, param_value, side_to_move,
               our_perspective, acc_low, acc_high,
        input  ready
    );

    modport sink (
        input  valid, mode, param_address, param_value, side_to_move,
               our_perspective, acc_low, acc_high,
        output ready
    );
endinterface

[sv/qmlp_rsp_if.sv]
interface qmlp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] score;

    modport source (
        output valid, score,
        input  ready
    );

    modport sink (
        input  valid, score,
        output ready
    );
endinterface

[sv/qmlp_layer.sv]
`include "quantized_mlp_evaluator_unit_macros.svh"

module qmlp_layer #(
    parameter int N_IN   = 8,
    parameter int N_OUT  = 8,
    parameter int N_SET  = 1,
    parameter int W_BASE = 0,
    parameter int B_BASE = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qmlp_pkg::ctl_t   in_ctl,
    input  qmlp_pkg::act_t   in_act [N_IN],
    output logic             out_valid,
    input  logic             out_ready,
    output qmlp_pkg::ctl_t   out_ctl,
    output qmlp_pkg::act_t   out_act [N_OUT]
);

    localparam int SET_SIZE = N_OUT * N_IN;

    logic [7:0]      w_reg [N_SET][N_OUT][N_IN];
    logic [15:0]     bias_reg [N_OUT];

    logic            a_valid_reg, a_valid_next;
    qmlp_pkg::ctl_t  a_ctl_reg;
    logic [15:0]     a_prod_reg [N_OUT][N_IN];
    logic [15:0]     a_prod_next [N_OUT][N_IN];

    logic            b_valid_reg, b_valid_next;
    qmlp_pkg::ctl_t  b_ctl_reg;
    qmlp_pkg::act_t  b_act_reg [N_OUT];
    qmlp_pkg::act_t  b_act_next [N_OUT];

    logic            a_take, b_take, in_fire, bias_wr;

    assign b_take   = !b_valid_reg || out_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;
    assign in_fire  = in_valid && a_take;
    // a write word updates the biases as it leaves the product stage
    assign bias_wr  = a_valid_reg && b_take && !a_ctl_reg.eval;

    // weight set follows side to move; set 0 is white
    always_comb
    begin
        for (int j = 0; j < N_OUT; j++)
        begin
            for (int k = 0; k < N_IN; k++)
            begin
                a_prod_next[j][k] = qmlp_pkg::mul_act_weight(in_act[k],
                    in_ctl.side ? w_reg[0][j][k] : w_reg[N_SET-1][j][k]);
            end
        end
    end

    // sum of products plus bias, wrapped to 16 bits, then activated
    always_comb
    begin
        logic [15:0] acc;
        acc = '0;
        for (int j = 0; j < N_OUT; j++)
        begin
            acc = bias_reg[j];
            for (int k = 0; k < N_IN; k++)
            begin
                acc = acc + a_prod_reg[j][k];
            end
            b_act_next[j] = qmlp_pkg::activate(acc);
        end
    end

    assign a_valid_next = a_take ? in_valid : a_valid_reg;
    assign b_valid_next = b_take ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_ctl_reg  <= in_ctl;
            a_prod_reg <= a_prod_next;
        end
        if (a_valid_reg && b_take)
        begin
            b_ctl_reg <= a_ctl_reg;
            b_act_reg <= b_act_next;
        end
    end

    // parameter writes, each entry decoded against its own address
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N_SET; s++)
        begin
            for (int j = 0; j < N_OUT; j++)
            begin
                for (int k = 0; k < N_IN; k++)
                begin
                    if (in_fire && !in_ctl.eval &&
                        int'(in_ctl.addr) == W_BASE + s * SET_SIZE + j * N_IN + k)
                    begin
                        w_reg[s][j][k] <= in_ctl.value[7:0];
                    end
                end
            end
        end
        for (int j = 0; j < N_OUT; j++)
        begin
            if (bias_wr && int'(a_ctl_reg.addr) == B_BASE + j)
            begin
                bias_reg[j] <= a_ctl_reg.value;
            end
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ctl   = b_ctl_reg;
    assign out_act   = b_act_reg;

    `QMLP_ASSERT_NXT(a_hold_chk, a_valid_reg && !b_take, a_valid_reg && $stable(a_ctl_reg))
    `QMLP_ASSERT_NXT(b_hold_chk, b_valid_reg && !out_ready, b_valid_reg && $stable(b_ctl_reg))
    `QMLP_ASSERT_NXT(a_load_chk, in_valid && in_ready, a_valid_reg)

endmodule

[sv/qmlp_out.sv]
`include "quantized_mlp_evaluator_unit_macros.svh"

module qmlp_out #(
    parameter int N_IN   = 4,
    parameter int W_BASE = 160,
    parameter int B_BASE = 176
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qmlp_pkg::ctl_t   in_ctl,
    input  qmlp_pkg::act_t   in_act [N_IN],
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      score
);

    logic [7:0]      w_reg [N_IN];
    logic [15:0]     bias_reg;

    logic            a_valid_reg, a_valid_next;
    qmlp_pkg::ctl_t  a_ctl_reg;
    logic [15:0]     a_prod_reg [N_IN];
    logic [15:0]     a_prod_next [N_IN];

    logic            b_valid_reg, b_valid_next;
    logic [15:0]     score_reg, score_next;

    logic            a_take, b_take, in_fire, bias_wr;

    assign b_take   = !b_valid_reg || out_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;
    assign in_fire  = in_valid && a_take;
    assign bias_wr  = a_valid_reg && b_take && !a_ctl_reg.eval;

    always_comb
    begin
        for (int k = 0; k < N_IN; k++)
        begin
            a_prod_next[k] = qmlp_pkg::mul_act_weight(in_act[k], w_reg[k]);
        end
    end

    // dot product plus bias, then flip to the engine's side if needed
    always_comb
    begin
        logic [15:0] acc;
        acc = bias_reg;
        for (int k = 0; k < N_IN; k++)
        begin
            acc = acc + a_prod_reg[k];
        end
        score_next = a_ctl_reg.ours ? acc : 16'(qmlp_pkg::PERSPECTIVE_OFFSET - acc);
    end

    assign a_valid_next = a_take ? in_valid : a_valid_reg;
    // write words end here and never reach the output
    assign b_valid_next = b_take ? (a_valid_reg && a_ctl_reg.eval) : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_ctl_reg  <= in_ctl;
            a_prod_reg <= a_prod_next;
        end
        if (a_valid_reg && b_take)
        begin
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N_IN; k++)
        begin
            if (in_fire && !in_ctl.eval && int'(in_ctl.addr) == W_BASE + k)
            begin
                w_reg[k] <= in_ctl.value[7:0];
            end
        end
        if (bias_wr && int'(a_ctl_reg.addr) == B_BASE)
        begin
            bias_reg <= a_ctl_reg.value;
        end
    end

    assign out_valid = b_valid_reg;
    assign score     = score_reg;

    `QMLP_ASSERT_NXT(wr_drop_chk, a_valid_reg && !a_ctl_reg.eval && b_take, !b_valid_reg)
    `QMLP_ASSERT_NXT(ev_pass_chk, a_valid_reg && a_ctl_reg.eval && b_take, b_valid_reg)
    `QMLP_ASSERT_NXT(a_hold_chk, a_valid_reg && !b_take, a_valid_reg && $stable(a_ctl_reg))

endmodule

[sv/quantized_mlp_evaluator_unit.sv]
// Quantized network evaluator. Every word on req is either a parameter write
// (mode 0: param_address selects an int8 weight or int16 bias, weights keep
// the low byte of param_value) or an evaluation (mode 1: eight int16
// accumulator values, side to move and perspective), and the unit takes one
// word per clock cycle for as long as rsp keeps up. Writes give no response;
// each evaluation gives exactly one score on rsp, in the order accepted.
// An evaluation's score is registered through seven stage registers on its
// way to rsp: an input register, then a product stage and a sum stage for
// each of the two hidden layers and for the output layer; the multiplier
// banks in the product stages set the one-word-per-cycle throughput.
// Writes and evaluations may be freely interleaved: each store is updated in
// the stage that reads it, so an evaluation sees exactly the writes accepted
// before it. Stores come up undefined after reset and must be fully loaded
// before the first evaluation.
module quantized_mlp_evaluator_unit #(
    parameter int INPUT_COUNT   = 8,
    parameter int FIRST_HIDDEN  = 8,
    parameter int SECOND_HIDDEN = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    qmlp_req_if.sink      req,
    qmlp_rsp_if.source    rsp
);

    // parameter address layout
    localparam int L1_SET_SIZE  = FIRST_HIDDEN * INPUT_COUNT;
    localparam int L2_BASE      = 2 * L1_SET_SIZE;
    localparam int FIN_BASE     = L2_BASE + SECOND_HIDDEN * FIRST_HIDDEN;
    localparam int WEIGHT_DEPTH = FIN_BASE + SECOND_HIDDEN;
    localparam int L1_BIAS      = WEIGHT_DEPTH;
    localparam int L2_BIAS      = L1_BIAS + FIRST_HIDDEN;
    localparam int FIN_BIAS     = L2_BIAS + SECOND_HIDDEN;

    // input register
    logic            s0_valid_reg, s0_valid_next;
    qmlp_pkg::ctl_t  s0_ctl_reg, s0_ctl_next;
    qmlp_pkg::act_t  s0_x_reg [INPUT_COUNT];
    qmlp_pkg::act_t  s0_x_next [INPUT_COUNT];
    logic            s0_take;

    // between layers
    logic            l1_ready, l1_valid, l2_ready, l2_valid, fin_ready, fin_valid;
    qmlp_pkg::ctl_t  l1_ctl, l2_ctl;
    qmlp_pkg::act_t  h1 [FIRST_HIDDEN];
    qmlp_pkg::act_t  h2 [SECOND_HIDDEN];
    logic [15:0]     fin_score;

    assign s0_take   = !s0_valid_reg || l1_ready;
    assign req.ready = s0_take;

    // collect the word's sideband
    always_comb
    begin
        s0_ctl_next.eval  = req.mode;
        s0_ctl_next.side  = req.side_to_move;
        s0_ctl_next.ours  = req.our_perspective;
        s0_ctl_next.addr  = req.param_address;
        s0_ctl_next.value = req.param_value;
    end

    // clip accumulators on the way in; inputs past the eighth are zero
    for (genvar g = 0; g < INPUT_COUNT; g++)
    begin : g_clip
        if (g < 4)
        begin : g_low
            assign s0_x_next[g] = qmlp_pkg::clip_input(req.acc_low[16*g +: 16]);
        end
        else if (g < 8)
        begin : g_high
            assign s0_x_next[g] = qmlp_pkg::clip_input(req.acc_high[16*(g-4) +: 16]);
        end
        else
        begin : g_zero
            assign s0_x_next[g] = '0;
        end
    end

    assign s0_valid_next = s0_take ? req.valid : s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_take && req.valid)
        begin
            s0_ctl_reg <= s0_ctl_next;
            s0_x_reg   <= s0_x_next;
        end
    end

    // first hidden layer: white and black weight sets
    qmlp_layer #(
        .N_IN   (INPUT_COUNT),
        .N_OUT  (FIRST_HIDDEN),
        .N_SET  (2),
        .W_BASE (0),
        .B_BASE (L1_BIAS)
    ) u_layer1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (l1_ready),
        .in_ctl    (s0_ctl_reg),
        .in_act    (s0_x_reg),
        .out_valid (l1_valid),
        .out_ready (l2_ready),
        .out_ctl   (l1_ctl),
        .out_act   (h1)
    );

    // second hidden layer
    qmlp_layer #(
        .N_IN   (FIRST_HIDDEN),
        .N_OUT  (SECOND_HIDDEN),
        .N_SET  (1),
        .W_BASE (L2_BASE),
        .B_BASE (L2_BIAS)
    ) u_layer2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l1_valid),
        .in_ready  (l2_ready),
        .in_ctl    (l1_ctl),
        .in_act    (h1),
        .out_valid (l2_valid),
        .out_ready (fin_ready),
        .out_ctl   (l2_ctl),
        .out_act   (h2)
    );

    // output layer; its last stage is the response register
    qmlp_out #(
        .N_IN   (SECOND_HIDDEN),
        .W_BASE (FIN_BASE),
        .B_BASE (FIN_BIAS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l2_valid),
        .in_ready  (fin_ready),
        .in_ctl    (l2_ctl),
        .in_act    (h2),
        .out_valid (fin_valid),
        .out_ready (rsp.ready),
        .score     (fin_score)
    );

    assign rsp.valid = fin_valid;
    assign rsp.score = $signed(fin_score);

endmodule

[bench/quantized_mlp_evaluator_unit_tb.sv]
// checks the quantized network evaluator against its own scoring model.
// parameter writes and evaluations go in through req, scores come back on rsp
// and are compared in order with the scores worked out when each eval word
// was accepted. both sides idle in random bursts until the last stretch.
module quantized_mlp_evaluator_unit_tb;

    // word kinds on req
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // network shape and parameter address map
    localparam int IN_COUNT      = 8;
    localparam int L1_COUNT      = 8;
    localparam int L2_COUNT      = 4;
    localparam int WHITE_L1_BASE = 0;
    localparam int BLACK_L1_BASE = IN_COUNT * L1_COUNT;
    localparam int L2_BASE       = 2 * IN_COUNT * L1_COUNT;
    localparam int OUT_BASE      = L2_BASE + L1_COUNT * L2_COUNT;
    localparam int WEIGHT_COUNT  = OUT_BASE + L2_COUNT;
    localparam int BIAS_COUNT    = L1_COUNT + L2_COUNT + 1;
    localparam int L2_BIAS       = L1_COUNT;
    localparam int OUT_BIAS      = L1_COUNT + L2_COUNT;
    localparam int PARAM_COUNT   = WEIGHT_COUNT + BIAS_COUNT;

    // arithmetic constants
    localparam int ACT_CEIL      = 127;
    localparam int HIDDEN_SHIFT  = 6;
    localparam int PERSPECTIVE   = 4096;

    // run control
    localparam int ITEM_COUNT    = 1100;
    localparam int QUIET_TAIL    = 300;
    localparam int PIPE_LATENCY  = 7;
    localparam int QUIET_LIMIT   = 2000;

    logic clk = 1'b0;
    logic rst_n;

    qmlp_req_if req ();
    qmlp_rsp_if rsp ();

    quantized_mlp_evaluator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // shadow copy of the parameter stores, updated as write words are accepted
    logic [7:0]  weight_mirror [WEIGHT_COUNT];
    logic [15:0] bias_mirror   [BIAS_COUNT];

    // scores still owed by the unit, oldest first
    logic signed [15:0] pending_scores [$];

    int  error_count  = 0;
    // random gaps on both sides, cleared for the last stretch of the run
    logic gaps_enabled = 1'b1;

    // int16 wrap, shift, relu and clamp of one hidden neuron
    function automatic int hidden_act(input int sum);
        logic signed [15:0] wrapped;
        int shifted;
        wrapped = 16'(sum);
        if (wrapped < 0)
        begin
            return 0;
        end
        shifted = int'(wrapped >>> HIDDEN_SHIFT);
        return (shifted > ACT_CEIL) ? ACT_CEIL : shifted;
    endfunction

    // score of one position with the current contents of the stores
    function automatic logic signed [15:0] net_score(input logic side, input logic ours,
                                                     input logic [63:0] lo,
                                                     input logic [63:0] hi);
        int x [IN_COUNT];
        int h1 [L1_COUNT];
        int h2 [L2_COUNT];
        int sum;
        int v;
        int set_base;
        logic [15:0] elem;
        logic signed [15:0] result;
        for (int i = 0; i < IN_COUNT; i++)
        begin
            elem = (i < 4) ? lo[16*i +: 16] : hi[16*(i-4) +: 16];
            v = int'($signed(elem));
            x[i] = (v < 0) ? 0 : ((v > ACT_CEIL) ? ACT_CEIL : v);
        end
        set_base = side ? WHITE_L1_BASE : BLACK_L1_BASE;
        for (int j = 0; j < L1_COUNT; j++)
        begin
            sum = 0;
            for (int i = 0; i < IN_COUNT; i++)
            begin
                sum += x[i] * int'($signed(weight_mirror[set_base + j*IN_COUNT + i]));
            end
            h1[j] = hidden_act(sum + int'($signed(bias_mirror[j])));
        end
        for (int j = 0; j < L2_COUNT; j++)
        begin
            sum = 0;
            for (int i = 0; i < L1_COUNT; i++)
            begin
                sum += h1[i] * int'($signed(weight_mirror[L2_BASE + j*L1_COUNT + i]));
            end
            h2[j] = hidden_act(sum + int'($signed(bias_mirror[L2_BIAS + j])));
        end
        sum = 0;
        for (int i = 0; i < L2_COUNT; i++)
        begin
            sum += h2[i] * int'($signed(weight_mirror[OUT_BASE + i]));
        end
        result = 16'(sum + int'($signed(bias_mirror[OUT_BIAS])));
        // other side's view, wraps in int16
        if (!ours)
        begin
            result = 16'(PERSPECTIVE - int'(result));
        end
        return result;
    endfunction

    // one accumulator element: mostly in the clip window, often at its edges
    function automatic logic [15:0] acc_element();
        logic [15:0] edges [6] = '{16'h8000, 16'hFFFF, 16'h0000, 16'd127, 16'd128,
                                   16'h7FFF};
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(0, 127));
            3:       return edges[$urandom_range(0, 5)];
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [63:0] acc_quad();
        return {acc_element(), acc_element(), acc_element(), acc_element()};
    endfunction

    // value for one parameter entry; weights are mostly small so activations
    // land in the middle of their range, the high byte is junk on purpose
    function automatic logic [15:0] param_for(input int addr);
        logic [7:0] w;
        if (addr < WEIGHT_COUNT)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                w = 8'($urandom);
            end
            else
            begin
                w = 8'(int'($urandom_range(0, 40)) - 20);
            end
            return {8'($urandom), w};
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    // drive one word and wait for it to be taken; starts and ends at a falling edge
    task automatic send_word(input logic md, input logic [7:0] addr,
                             input logic [15:0] val, input logic side,
                             input logic ours, input logic [63:0] lo,
                             input logic [63:0] hi);
        if (gaps_enabled && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.valid           <= 1'b1;
        req.mode            <= md;
        req.param_address   <= addr;
        req.param_value     <= val;
        req.side_to_move    <= side;
        req.our_perspective <= ours;
        req.acc_low         <= lo;
        req.acc_high        <= hi;
        do @(posedge clk); while (!req.ready);
        // word taken at this edge
        if (md == MODE_WRITE)
        begin
            if (addr < WEIGHT_COUNT)
            begin
                weight_mirror[addr] = val[7:0];
            end
            else if (addr < PARAM_COUNT)
            begin
                bias_mirror[addr - WEIGHT_COUNT] = val;
            end
        end
        else
        begin
            pending_scores.push_back(net_score(side, ours, lo, hi));
        end
        @(negedge clk);
    endtask

    // unused fields of a write word carry random junk
    task automatic write_param(input int addr, input logic [15:0] val);
        send_word(MODE_WRITE, 8'(addr), val, 1'($urandom), 1'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic evaluate(input logic side, input logic ours,
                            input logic [63:0] lo, input logic [63:0] hi);
        send_word(MODE_EVAL, 8'($urandom), 16'($urandom), side, ours, lo, hi);
    endtask

    // hold the sender until every owed score is back
    task automatic wait_for_drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending_scores.size() != 0) @(negedge clk);
    endtask

    task automatic load_all_params();
        for (int a = 0; a < PARAM_COUNT; a++)
        begin
            write_param(a, param_for(a));
        end
    endtask

    // every entry is written before any evaluation reads it
    task automatic test_full_load();
        load_all_params();
        evaluate(1'b1, 1'b1, acc_quad(), acc_quad());
    endtask

    // inputs below zero, at the window edges and far above it
    task automatic test_input_clipping();
        evaluate(1'b1, 1'b1, {16'd1, 16'd0, 16'hFFFF, 16'h8000},
                 {16'd64, 16'h7FFF, 16'd128, 16'd127});
        evaluate(1'b0, 1'b1, {4{16'd127}}, {4{16'd127}});
        evaluate(1'b1, 1'b1, {4{16'h8000}}, {4{16'h8000}});
        evaluate(1'b0, 1'b0, {4{16'h7FFF}}, {4{16'h7FFF}});
    endtask

    // both weight sets, both perspectives, same accumulator
    task automatic test_side_and_perspective();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = acc_quad();
        hi = acc_quad();
        for (int s = 0; s < 2; s++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                evaluate(1'(s), 1'(p), lo, hi);
            end
        end
    endtask

    // layer-one sum overflows int16, then the bias addition wraps both ways
    task automatic test_accumulator_wrap();
        for (int i = 0; i < IN_COUNT; i++)
        begin
            write_param(WHITE_L1_BASE + i, 16'hA57F);
        end
        // most negative weight, high byte ignored
        write_param(WHITE_L1_BASE + IN_COUNT, 16'h3480);
        write_param(WEIGHT_COUNT + 0, 16'h7FFF);
        evaluate(1'b1, 1'b1, {4{16'd127}}, {4{16'd127}});
        write_param(WEIGHT_COUNT + 0, 16'h8000);
        evaluate(1'b1, 1'b1, {4{16'd127}}, {4{16'd127}});
    endtask

    // output bias alone sets the score, so the perspective flip wraps
    task automatic test_output_extremes();
        for (int i = 0; i < L2_COUNT; i++)
        begin
            write_param(OUT_BASE + i, 16'h0000);
        end
        write_param(WEIGHT_COUNT + OUT_BIAS, 16'h8000);
        evaluate(1'b0, 1'b0, acc_quad(), acc_quad());
        evaluate(1'b1, 1'b1, acc_quad(), acc_quad());
        write_param(WEIGHT_COUNT + OUT_BIAS, 16'h7FFF);
        evaluate(1'b1, 1'b0, acc_quad(), acc_quad());
    endtask

    // writes past the map must leave the stores alone
    task automatic test_ignored_addresses();
        write_param(PARAM_COUNT, 16'h1234);
        write_param(200, 16'hFFFF);
        write_param(255, 16'h5A5A);
        evaluate(1'b0, 1'b1, acc_quad(), acc_quad());
    endtask

    // mixed traffic: mostly evaluations, parameter updates interleaved,
    // some junk writes; one full drain a third of the way in, no gaps at the end
    task automatic test_random_traffic();
        int sent;
        int pick;
        int addr;
        sent = 0;
        load_all_params();
        while (sent < ITEM_COUNT)
        begin
            if (sent == ITEM_COUNT / 3)
            begin
                wait_for_drain();
            end
            if (sent == ITEM_COUNT - QUIET_TAIL)
            begin
                gaps_enabled = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                write_param($urandom_range(PARAM_COUNT, 255), 16'($urandom));
            end
            else if (pick < 28)
            begin
                addr = $urandom_range(0, PARAM_COUNT - 1);
                write_param(addr, param_for(addr));
                sent++;
            end
            else
            begin
                evaluate(1'($urandom), 1'($urandom), acc_quad(), acc_quad());
                sent++;
            end
        end
    endtask

    // response side: ready drops in random bursts while gaps are on
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 6) - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // every score word taken is matched against the oldest owed score
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t unexpected score word: expected none actual %0d",
                         $time, rsp.score);
                error_count++;
            end
            else
            begin
                if (rsp.score !== pending_scores[0])
                begin
                    $display("%0t score mismatch: expected %0d actual %0d",
                             $time, pending_scores[0], rsp.score);
                    error_count++;
                end
                void'(pending_scores.pop_front());
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[quantized_mlp_evaluator_unit] ERROR");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        req.valid            = 1'b0;
        req.mode             = MODE_WRITE;
        req.param_address    = '0;
        req.param_value      = '0;
        req.side_to_move     = 1'b0;
        req.our_perspective  = 1'b0;
        req.acc_low          = '0;
        req.acc_high         = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_full_load();
        test_input_clipping();
        test_side_and_perspective();
        test_accumulator_wrap();
        test_output_extremes();
        test_ignored_addresses();
        test_random_traffic();

        req.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        // let any late word show up before the verdict
        repeat (3 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0 && pending_scores.size() == 0)
        begin
            $display("[quantized_mlp_evaluator_unit] OK");
        end
        else
        begin
            $display("[quantized_mlp_evaluator_unit] ERROR");
        end
        $finish;
    end

endmodule
